FILE: rtl/round_robin_process_scheduler_macros.svh
// Assertion macros shared by the round-robin process scheduler RTL.
`ifndef ROUND_ROBIN_PROCESS_SCHEDULER_MACROS_SVH
`define ROUND_ROBIN_PROCESS_SCHEDULER_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define RRPS_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// An implication checked in the same cycle.
`define RRPS_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

FILE: rtl/rrps_pkg.sv
// Package with the types and constants of the round-robin process scheduler.
`default_nettype none

package rrps_pkg;

  localparam int unsigned DEFAULT_MAX_SLOTS = 16;
  localparam int unsigned REQ_W             = 2;
  localparam int unsigned STATUS_W          = 2;
  localparam int unsigned ADDR_W            = 32;
  localparam int unsigned PID_W             = 32;
  localparam int unsigned SLOT_FIELD_W      = 4;

  // Request codes carried on req_type.
  typedef enum logic [REQ_W-1:0] {
    REQ_CREATE = 2'd0,
    REQ_EXIT   = 2'd1,
    REQ_SCHED  = 2'd2
  } req_t;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    STAT_DONE      = 2'd0,
    STAT_FULL      = 2'd1,
    STAT_IDLE_EXIT = 2'd2
  } status_t;

  // Sequencer states.
  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EXEC = 4'b0010,
    S_READ = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

endpackage

`default_nettype wire

FILE: rtl/rrps_ram.sv
// Simple dual-port synchronous RAM with one write port and a registered read port.
`default_nettype none

module rrps_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/round_robin_process_scheduler.sv
// Top level of the round-robin process scheduler: sequencer, list registers and memories.
//
// Usage: one request word enters on the in channel (valid/ready) and exactly one
// result word leaves on the out channel (valid/ready). A request is taken only
// while the sequencer is idle. A create, an unknown request, an exit of idle, or
// an exit or schedule with an empty ready list goes from S_EXEC straight to
// S_DONE; a schedule or exit that pops the ready list passes through S_READ
// between them, because the link of the list head and the pid of the new slot
// come out of the registered read ports of the memories. A new request is not
// taken before the result of the last one is loaded into the output register.
// The free-slot search is a fill count, since slots are handed out in rising
// order and never return to the free pool. The ready list keeps head and tail
// registers, so appending at the tail needs no walk. After the synchronous reset,
// idle slot 0 runs with pid 0, the list is empty and the next pid is 1; no
// clearing pass is needed, because a memory entry is only used after it has been
// written. When the receiver stalls, the finished result waits in the working
// registers and the sequencer waits in S_DONE before it returns to idle.
`default_nettype none
`include "round_robin_process_scheduler_macros.svh"

module round_robin_process_scheduler #(
  parameter int unsigned MAX_SLOTS = rrps_pkg::DEFAULT_MAX_SLOTS
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [rrps_pkg::REQ_W-1:0]        req_type,
  input  logic [rrps_pkg::ADDR_W-1:0]       entry_address,
  input  logic [rrps_pkg::ADDR_W-1:0]       user_stack_top,
  input  logic [rrps_pkg::ADDR_W-1:0]       kernel_stack_top,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [rrps_pkg::STATUS_W-1:0]     status,
  output logic [rrps_pkg::PID_W-1:0]        created_pid,
  output logic                              switched,
  output logic [rrps_pkg::SLOT_FIELD_W-1:0] old_slot,
  output logic [rrps_pkg::SLOT_FIELD_W-1:0] running_slot,
  output logic [rrps_pkg::PID_W-1:0]        running_pid
);

  import rrps_pkg::*;

  localparam int unsigned SLOT_W   = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int unsigned CNT_W    = $clog2(MAX_SLOTS + 1);
  localparam int unsigned PAD_W    = (SLOT_W > SLOT_FIELD_W) ? SLOT_W : SLOT_FIELD_W;
  localparam int unsigned RECORD_W = PID_W + 3 * ADDR_W;

  // Control state.
  state_t             state;
  logic [SLOT_W-1:0]  current;
  logic [PID_W-1:0]   cur_pid;
  logic               list_empty;
  logic [CNT_W-1:0]   alloc_cnt;
  logic [PID_W-1:0]   pid_counter;

  // List pointers, valid only while the list is not empty.
  logic [SLOT_W-1:0]  head;
  logic [SLOT_W-1:0]  tail;

  // Per-request working registers.
  req_t               req_q;
  logic [SLOT_W-1:0]  old_q;
  logic               last_q;
  logic               appended_q;
  status_t            status_q;
  logic [PID_W-1:0]   created_q;
  logic               switched_q;

  // Memory ports.
  logic               link_wr_en;
  logic [SLOT_W-1:0]  link_wr_addr;
  logic [SLOT_W-1:0]  link_wr_data;
  logic               mem_rd_en;
  logic [SLOT_W-1:0]  link_rd_data;
  logic               rec_wr_en;
  logic [RECORD_W-1:0] rec_wr_data;
  logic [RECORD_W-1:0] rec_rd_data;

  logic               accept;
  logic               full;
  logic [SLOT_W-1:0]  alloc_slot;
  logic               out_free;
  logic [PAD_W-1:0]   old_pad;
  logic [PAD_W-1:0]   cur_pad;

  assign in_ready   = (state == S_IDLE);
  assign accept     = in_valid && in_ready;
  assign full       = (alloc_cnt == CNT_W'(MAX_SLOTS));
  assign alloc_slot = alloc_cnt[SLOT_W-1:0];
  assign out_free   = !out_valid || out_ready;
  assign old_pad    = PAD_W'(old_q);
  assign cur_pad    = PAD_W'(current);

  // The slot record (pid and the three words of a new process) is written as the
  // create request is accepted, so the stack words need no holding register.
  assign rec_wr_en   = accept && (req_t'(req_type) == REQ_CREATE) && !full;
  assign rec_wr_data = {kernel_stack_top, user_stack_top, entry_address, pid_counter};

  // A create links the new slot in front of the old head; a schedule links the
  // running slot behind the old tail. Only links of list members that are not
  // the tail are ever read, and each of those has been written.
  assign link_wr_en   = (state == S_EXEC) &&
                        (((req_q == REQ_CREATE) && !full) ||
                         ((req_q == REQ_SCHED) && !list_empty));
  assign link_wr_addr = (req_q == REQ_CREATE) ? alloc_slot : tail;
  assign link_wr_data = (req_q == REQ_CREATE) ? head : current;

  // Link and record of the list head are read together; the data is used in the
  // next cycle. If the head is also the tail its link is never used, which also
  // covers a read of the entry that is being written in the same cycle.
  assign mem_rd_en = (state == S_EXEC);

  rrps_ram #(
    .WIDTH (SLOT_W),
    .DEPTH (MAX_SLOTS)
  ) u_link_ram (
    .clk     (clk),
    .wr_en   (link_wr_en),
    .wr_addr (link_wr_addr),
    .wr_data (link_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (head),
    .rd_data (link_rd_data)
  );

  rrps_ram #(
    .WIDTH (RECORD_W),
    .DEPTH (MAX_SLOTS)
  ) u_record_ram (
    .clk     (clk),
    .wr_en   (rec_wr_en),
    .wr_addr (alloc_slot),
    .wr_data (rec_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (head),
    .rd_data (rec_rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      current     <= '0;
      cur_pid     <= '0;
      list_empty  <= 1'b1;
      alloc_cnt   <= CNT_W'(1);
      pid_counter <= PID_W'(1);
      out_valid   <= 1'b0;
    end else begin
      // In S_DONE a taken word is replaced by the finished result in the same cycle.
      if (out_valid && out_ready && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            req_q <= req_t'(req_type);
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          old_q      <= current;
          status_q   <= STAT_DONE;
          created_q  <= '0;
          switched_q <= 1'b0;
          state      <= S_DONE;
          unique case (req_q)
            REQ_CREATE: begin
              if (full) begin
                status_q <= STAT_FULL;
              end else begin
                created_q   <= pid_counter;
                pid_counter <= pid_counter + PID_W'(1);
                alloc_cnt   <= alloc_cnt + CNT_W'(1);
                head        <= alloc_slot;
                if (list_empty) begin
                  tail <= alloc_slot;
                end
                list_empty  <= 1'b0;
              end
            end
            REQ_EXIT, REQ_SCHED: begin
              if ((req_q == REQ_EXIT) && (current == '0)) begin
                status_q <= STAT_IDLE_EXIT;
              end else if (list_empty) begin
                // A yield with nothing else ready switches the slot to itself;
                // an exit with nothing ready falls back to idle.
                if (req_q == REQ_SCHED) begin
                  switched_q <= 1'b1;
                end else begin
                  current <= '0;
                  cur_pid <= '0;
                end
              end else begin
                appended_q <= (req_q == REQ_SCHED);
                last_q     <= (head == tail);
                if (req_q == REQ_SCHED) begin
                  tail <= current;
                end
                state <= S_READ;
              end
            end
            default: begin
            end
          endcase
        end
        S_READ: begin
          // Pop the head. Slot 0 keeps pid 0 and its record is never written.
          current    <= head;
          cur_pid    <= (head == '0) ? '0 : rec_rd_data[PID_W-1:0];
          switched_q <= 1'b1;
          if (last_q) begin
            if (appended_q) begin
              head <= current;
            end else begin
              list_empty <= 1'b1;
            end
          end else begin
            head <= link_rd_data;
          end
          state <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            out_valid    <= 1'b1;
            status       <= status_q;
            created_pid  <= created_q;
            switched     <= switched_q;
            old_slot     <= old_pad[SLOT_FIELD_W-1:0];
            running_slot <= cur_pad[SLOT_FIELD_W-1:0];
            running_pid  <= cur_pid;
            state        <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // The running slot has always been handed out.
  `RRPS_ASSERT_ALWAYS(a_current_allocated, CNT_W'(current) < alloc_cnt, "running slot not allocated")

  // Every slot on the ready list has been handed out.
  `RRPS_ASSERT_IMPLY(a_list_allocated, !list_empty, (CNT_W'(head) < alloc_cnt) && (CNT_W'(tail) < alloc_cnt), "ready list holds an unallocated slot")

  // A switch is only reported by a request that completed normally.
  `RRPS_ASSERT_IMPLY(a_switch_status, out_valid && switched, status == STAT_DONE, "switch reported with error status")

endmodule

`default_nettype wire

FILE: tb/sv/tb.sv
// Self-checking testbench for the round-robin process scheduler.
`timescale 1ns / 1ps

module tb;
  import rrps_pkg::*;

  // The table size of the block under test and the marker for an empty link.
  localparam int unsigned SLOTS = DEFAULT_MAX_SLOTS;
  localparam int unsigned NIL = SLOTS;

  // The block also has to survive the one request code that the package leaves unnamed.
  localparam logic [REQ_W-1:0] REQ_UNKNOWN = 2'd3;

  // If nothing moves on either channel for this many cycles, the run is declared hung.
  localparam int unsigned HANG_LIMIT = 1000;

  // The long receiver hold-off starts after this many result words and lasts this long.
  localparam int unsigned HOLD_AFTER = 400;
  localparam int unsigned HOLD_CYCLES = 150;

  typedef enum logic [1:0] {
    SLOT_FREE    = 2'd0,
    SLOT_READY   = 2'd1,
    SLOT_RUNNING = 2'd2,
    SLOT_ZOMBIE  = 2'd3
  } slot_state_t;

  // One request word, plus a flag that makes the sender wait for every open result first.
  typedef struct {
    logic [REQ_W-1:0]  kind;
    logic [ADDR_W-1:0] entry;
    logic [ADDR_W-1:0] ustack;
    logic [ADDR_W-1:0] kstack;
    bit                drain_first;
  } sched_req_t;

  // One result word as the block should report it.
  typedef struct {
    status_t                 st;
    logic [PID_W-1:0]        cpid;
    logic                    sw;
    logic [SLOT_FIELD_W-1:0] old_s;
    logic [SLOT_FIELD_W-1:0] run_s;
    logic [PID_W-1:0]        rpid;
  } sched_result_t;

  logic clk;
  logic rst = 1'b1;

  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic [REQ_W-1:0]        req_type = '0;
  logic [ADDR_W-1:0]       entry_address = '0;
  logic [ADDR_W-1:0]       user_stack_top = '0;
  logic [ADDR_W-1:0]       kernel_stack_top = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic [STATUS_W-1:0]     status;
  logic [PID_W-1:0]        created_pid;
  logic                    switched;
  logic [SLOT_FIELD_W-1:0] old_slot;
  logic [SLOT_FIELD_W-1:0] running_slot;
  logic [PID_W-1:0]        running_pid;

  round_robin_process_scheduler #(
    .MAX_SLOTS(SLOTS)
  ) dut (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .req_type         (req_type),
    .entry_address    (entry_address),
    .user_stack_top   (user_stack_top),
    .kernel_stack_top (kernel_stack_top),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .status           (status),
    .created_pid      (created_pid),
    .switched         (switched),
    .old_slot         (old_slot),
    .running_slot     (running_slot),
    .running_pid      (running_pid)
  );

  // Shadow copy of the process table. Entry and stack words are never reported, so
  // only the fields that shape a result are kept.
  logic [PID_W-1:0] pid_of [SLOTS];
  slot_state_t      state_of [SLOTS];
  int unsigned      next_in_list [SLOTS];
  int unsigned      list_head;
  int unsigned      running_now;
  logic [PID_W-1:0] pid_to_give;

  sched_req_t    pending_reqs[$];
  sched_result_t expected_results[$];
  sched_req_t    cur_req;
  int            errors = 0;

  // Requeues a still-running current slot at the tail of the ready list, then pops the
  // head, or falls back to the idle slot when the list is empty. Returns the switch flag.
  function automatic logic rotate_ready();
    int unsigned tail;
    int unsigned steps;
    if (state_of[running_now] == SLOT_RUNNING) begin
      state_of[running_now] = SLOT_READY;
      next_in_list[running_now] = NIL;
      if (list_head < SLOTS) begin
        tail = list_head;
        steps = 0;
        // The walk is bounded by the table size, just as the block's list is.
        while (next_in_list[tail] < SLOTS && steps < SLOTS) begin
          tail = next_in_list[tail];
          steps++;
        end
        next_in_list[tail] = running_now;
      end else begin
        list_head = running_now;
      end
    end
    if (list_head < SLOTS) begin
      tail = list_head;
      list_head = next_in_list[tail];
      next_in_list[tail] = NIL;
      running_now = tail;
      state_of[tail] = SLOT_RUNNING;
      return 1'b1;
    end
    running_now = 0;
    state_of[0] = SLOT_RUNNING;
    return 1'b0;
  endfunction

  // Applies one accepted request to the shadow table and returns the result word it causes.
  function automatic sched_result_t predict_request(sched_req_t r);
    sched_result_t res;
    int unsigned free_slot;
    res.st = STAT_DONE;
    res.cpid = '0;
    res.sw = 1'b0;
    res.old_s = running_now[SLOT_FIELD_W-1:0];
    case (r.kind)
      REQ_CREATE: begin
        // Slots are taken lowest first from 1 upward; a zombie is never handed out again.
        free_slot = NIL;
        for (int i = 1; i < SLOTS; i++) begin
          if (state_of[i] == SLOT_FREE && free_slot == NIL) free_slot = i;
        end
        if (free_slot < SLOTS) begin
          pid_of[free_slot] = pid_to_give;
          res.cpid = pid_to_give;
          pid_to_give = pid_to_give + PID_W'(1);
          state_of[free_slot] = SLOT_READY;
          next_in_list[free_slot] = list_head;
          list_head = free_slot;
        end else begin
          res.st = STAT_FULL;
        end
      end
      REQ_EXIT: begin
        // The idle slot cannot exit; anything else turns zombie and gives up the CPU.
        if (running_now == 0) begin
          res.st = STAT_IDLE_EXIT;
        end else begin
          state_of[running_now] = SLOT_ZOMBIE;
          res.sw = rotate_ready();
        end
      end
      REQ_SCHED: begin
        res.sw = rotate_ready();
      end
      default: begin
        // An unknown request leaves the table alone and reports plain success.
      end
    endcase
    res.run_s = running_now[SLOT_FIELD_W-1:0];
    res.rpid = pid_of[running_now];
    return res;
  endfunction

  task automatic add_req(input logic [REQ_W-1:0] kind, input logic [ADDR_W-1:0] entry,
                         input logic [ADDR_W-1:0] ustack, input logic [ADDR_W-1:0] kstack,
                         input bit drain_first);
    sched_req_t r;
    r.kind = kind;
    r.entry = entry;
    r.ustack = ustack;
    r.kstack = kstack;
    r.drain_first = drain_first;
    pending_reqs.push_back(r);
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Sender. A word is offered in bursts of random length with random gaps after them.
  // The sender also keeps its own count of words in flight, from handshakes on both
  // channels, so that a request marked to drain first waits until every result is back.
  int unsigned burst_left;
  int unsigned gap_left;
  int          outstanding;

  always @(posedge clk) begin : sender
    int         live;
    sched_req_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
      burst_left <= 0;
      gap_left <= 0;
      outstanding <= 0;
    end else begin
      if (in_valid && in_ready) expected_results.push_back(predict_request(cur_req));
      live = outstanding + int'(in_valid && in_ready) - int'(out_valid && out_ready);
      outstanding <= live;
      // A word on offer stays put, unchanged, until the block takes it.
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (pending_reqs.size() > 0 && !(pending_reqs[0].drain_first && live != 0)) begin
          nxt = pending_reqs.pop_front();
          cur_req <= nxt;
          in_valid <= 1'b1;
          req_type <= nxt.kind;
          entry_address <= nxt.entry;
          user_stack_top <= nxt.ustack;
          kernel_stack_top <= nxt.kstack;
          if (burst_left <= 1) begin
            // A quarter of the bursts run straight into the next one with no gap.
            burst_left <= $urandom_range(1, 30);
            gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver. It changes between never stalling, stalling half the time and stalling a
  // quarter of the time, in stretches of random length. Once, after a few hundred result
  // words, it holds off for a long stretch so that the block backs up into its input.
  int unsigned stall_mode;
  int unsigned stall_timer;
  int unsigned hold_left;
  int unsigned words_taken;
  bit          hold_done;

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      stall_mode <= 0;
      stall_timer <= 0;
      hold_left <= 0;
      words_taken <= 0;
      hold_done <= 1'b0;
    end else begin
      if (out_valid && out_ready) words_taken <= words_taken + 1;
      if (!hold_done && words_taken >= HOLD_AFTER) begin
        hold_done <= 1'b1;
        hold_left <= HOLD_CYCLES;
        out_ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_ready <= 1'b0;
      end else begin
        if (stall_timer == 0) begin
          stall_mode <= $urandom_range(0, 2);
          stall_timer <= $urandom_range(16, 80);
        end else begin
          stall_timer <= stall_timer - 1;
        end
        case (stall_mode)
          0: out_ready <= 1'b1;
          1: out_ready <= 1'($urandom_range(0, 1));
          default: out_ready <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  // Monitor. Every result word is matched against the oldest prediction, field by field.
  always @(posedge clk) begin : monitor
    sched_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        $error("result word with no request waiting for it");
        errors++;
      end else begin
        want = expected_results.pop_front();
        if (status !== want.st) begin
          $error("status: expected %0d, got %0d", want.st, status);
          errors++;
        end
        if (created_pid !== want.cpid) begin
          $error("created_pid: expected %0d, got %0d", want.cpid, created_pid);
          errors++;
        end
        if (switched !== want.sw) begin
          $error("switched: expected %0d, got %0d", want.sw, switched);
          errors++;
        end
        if (old_slot !== want.old_s) begin
          $error("old_slot: expected %0d, got %0d", want.old_s, old_slot);
          errors++;
        end
        if (running_slot !== want.run_s) begin
          $error("running_slot: expected %0d, got %0d", want.run_s, running_slot);
          errors++;
        end
        if (running_pid !== want.rpid) begin
          $error("running_pid: expected %0d, got %0d", want.rpid, running_pid);
          errors++;
        end
      end
    end
  end

  // Watchdog. Any handshake on either channel counts as progress.
  int unsigned quiet_cycles;

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= HANG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int               pick;
    logic [REQ_W-1:0] kind;

    // After reset only the idle slot runs, with pid 0, and the ready list is empty.
    for (int i = 0; i < SLOTS; i++) begin
      pid_of[i] = '0;
      state_of[i] = SLOT_FREE;
      next_in_list[i] = NIL;
    end
    state_of[0] = SLOT_RUNNING;
    list_head = NIL;
    running_now = 0;
    pid_to_give = 1;

    // Directed opening. A schedule on the empty list requeues idle and pops it again,
    // a switch of a slot to itself. Then an exit of idle, an unknown request, creates
    // with the field extremes, rotation through the list, and a series of exits and schedules.
    add_req(REQ_SCHED, '0, '0, '0, 1'b0);
    add_req(REQ_EXIT, '0, '0, '0, 1'b0);
    add_req(REQ_UNKNOWN, '1, '1, '1, 1'b0);
    add_req(REQ_CREATE, '0, '0, '0, 1'b0);
    add_req(REQ_CREATE, '1, '1, '1, 1'b0);
    add_req(REQ_CREATE, 32'hAAAA_5555, 32'h5555_AAAA, 32'hA5A5_5A5A, 1'b0);
    add_req(REQ_SCHED, '0, '0, '0, 1'b0);
    add_req(REQ_SCHED, '1, '0, '1, 1'b0);
    add_req(REQ_SCHED, '0, '1, '0, 1'b0);
    add_req(REQ_SCHED, '0, '0, '0, 1'b0);
    add_req(REQ_EXIT, '0, '0, '0, 1'b0);
    add_req(REQ_SCHED, '0, '0, '0, 1'b0);
    add_req(REQ_UNKNOWN, '0, '0, '0, 1'b0);
    add_req(REQ_CREATE, 32'h5A5A_A5A5, 32'h0000_FFFF, 32'hFFFF_0000, 1'b0);
    add_req(REQ_EXIT, '0, '0, '0, 1'b0);
    add_req(REQ_EXIT, '0, '0, '0, 1'b0);
    add_req(REQ_SCHED, '0, '0, '0, 1'b0);
    add_req(REQ_EXIT, '0, '0, '0, 1'b0);
    add_req(REQ_EXIT, '0, '0, '0, 1'b0);
    add_req(REQ_SCHED, '0, '0, '0, 1'b0);

    // Random part. Creates and exits are kept rare so that the table fills slowly, the
    // ready list grows and shrinks for most of the run, and the full table still shows
    // up near the end. Now and then a request waits for the pipeline to drain first.
    for (int n = 0; n < 1030; n++) begin
      pick = $urandom_range(0, 999);
      if (pick < 25) kind = REQ_CREATE;
      else if (pick < 40) kind = REQ_EXIT;
      else if (pick < 70) kind = REQ_UNKNOWN;
      else kind = REQ_SCHED;
      add_req(kind, $urandom, $urandom, $urandom, n == 0 || $urandom_range(0, 99) == 0);
    end

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Wait until every request word has gone in and every result word has come out,
    // then give the block a little longer to show any stray result.
    do @(negedge clk);
    while (pending_reqs.size() != 0 || in_valid || outstanding != 0);
    repeat (20) @(posedge clk);

    if (errors == 0 && expected_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
